@@ rtl/fpe_pkg.sv @@
// Shared types, constants and helpers for the frustum plane extraction block.
// No dependencies; every other file in rtl/ uses this package.
`timescale 1ns / 1ps
package fpe_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int NUM_W      = 33 + FRAC_BITS;   // |e| << FRAC_BITS, also quotient width
  localparam int SQRT_STEPS = 34;               // radicand is 68 bits, two bits a step
  localparam int CNT_W      = $clog2(NUM_W + 1);

  localparam logic [2:0] PLANE_LEFT   = 3'd0;
  localparam logic [2:0] PLANE_RIGHT  = 3'd1;
  localparam logic [2:0] PLANE_TOP    = 3'd2;
  localparam logic [2:0] PLANE_BOTTOM = 3'd3;
  localparam logic [2:0] PLANE_NEAR   = 3'd4;
  localparam logic [2:0] PLANE_FAR    = 3'd5;

  typedef enum logic {F_COLLECT, F_EMIT} front_state_t;
  typedef enum logic [2:0] {B_IDLE, B_SQ, B_SQRT, B_DIV, B_OUT} back_state_t;

  typedef struct packed {
    logic signed [31:0] col_x;
    logic signed [31:0] col_y;
    logic signed [31:0] col_z;
    logic signed [31:0] col_w;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] plane_a;
    logic signed [31:0] plane_b;
    logic signed [31:0] plane_c;
    logic signed [31:0] plane_d;
    logic [2:0]         plane_index;
    logic               degenerate;
    logic               last_plane;
  } out_item_t;

  // unnormalized plane, each element a 33-bit signed sum
  typedef struct packed {
    logic [3:0][32:0] e;
    logic [2:0]       idx;
  } raw_plane_t;

  function automatic logic [32:0] mag(input logic [32:0] v);
    return v[32] ? (~v + 33'd1) : v;
  endfunction

  function automatic logic plane_adds(input logic [2:0] p);
    return (p == PLANE_LEFT) || (p == PLANE_BOTTOM) || (p == PLANE_NEAR);
  endfunction

  function automatic logic [31:0] sat_q(input logic [NUM_W-1:0] q, input logic neg);
    logic [NUM_W-1:0] lim;
    lim = {{(NUM_W-32){1'b0}}, 32'h8000_0000};
    if (neg) begin
      if (q > lim) return 32'h8000_0000;
      return ~q[31:0] + 32'd1;
    end
    if (q >= lim) return 32'h7fff_ffff;
    return q[31:0];
  endfunction

endpackage

@@ rtl/fpe_front.sv @@
// Front end: collects the four matrix columns and forms the six raw planes.
// Depends on fpe_pkg.
`timescale 1ns / 1ps
module fpe_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  fpe_pkg::in_item_t      col,
  output logic                   q_push,
  input  logic                   q_full,
  output fpe_pkg::raw_plane_t    q_data
);

  fpe_pkg::front_state_t state_r, state_nxt;
  fpe_pkg::in_item_t     col_r [4];
  logic [1:0]            ccnt_r, ccnt_nxt;
  logic [2:0]            pidx_r, pidx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpe_pkg::F_COLLECT;
      ccnt_r  <= 2'd0;
      pidx_r  <= 3'd0;
    end else begin
      state_r <= state_nxt;
      ccnt_r  <= ccnt_nxt;
      pidx_r  <= pidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) col_r[ccnt_r] <= col;
  end

  // element j of plane p comes from column j: w plus or minus x, y or z
  always_comb begin
    logic signed [31:0] v;
    q_data.idx = pidx_r;
    for (int j = 0; j < 4; j++) begin
      case (pidx_r[2:1])
        2'd0:    v = col_r[j].col_x;
        2'd1:    v = col_r[j].col_y;
        default: v = col_r[j].col_z;
      endcase
      if (fpe_pkg::plane_adds(pidx_r))
        q_data.e[j] = {col_r[j].col_w[31], col_r[j].col_w} + {v[31], v};
      else
        q_data.e[j] = {col_r[j].col_w[31], col_r[j].col_w} - {v[31], v};
    end
  end

  always_comb begin
    state_nxt = state_r;
    ccnt_nxt  = ccnt_r;
    pidx_nxt  = pidx_r;
    full      = 1'b1;
    q_push    = 1'b0;
    case (state_r)
      fpe_pkg::F_COLLECT: begin
        full = 1'b0;
        if (push) begin
          ccnt_nxt = ccnt_r + 2'd1;
          if (ccnt_r == 2'd3) begin
            state_nxt = fpe_pkg::F_EMIT;
            pidx_nxt  = fpe_pkg::PLANE_LEFT;
          end
        end
      end
      fpe_pkg::F_EMIT: begin
        if (!q_full) begin
          q_push   = 1'b1;
          pidx_nxt = pidx_r + 3'd1;
          if (pidx_r == fpe_pkg::PLANE_FAR) state_nxt = fpe_pkg::F_COLLECT;
        end
      end
      default: state_nxt = fpe_pkg::F_COLLECT;
    endcase
  end

endmodule

@@ rtl/fpe_queue.sv @@
// Two-entry queue of raw planes between the front and back ends.
// Depends on fpe_pkg.
`timescale 1ns / 1ps
module fpe_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  fpe_pkg::raw_plane_t wdata,
  input  logic                pop,
  output logic                empty,
  output fpe_pkg::raw_plane_t rdata
);

  fpe_pkg::raw_plane_t mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (do_push) wptr_r <= ~wptr_r;
      if (do_pop)  rptr_r <= ~rptr_r;
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= wdata;
  end

  assert property (@(posedge clk) disable iff (!rst_n) count_r != 2'd3)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (wptr_r == rptr_r) |-> (count_r == 2'd0 || count_r == 2'd2))
    else $error("queue pointers disagree with count");
  assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> count_r == $past(count_r) + 2'd1)
    else $error("queue push lost");

endmodule

@@ rtl/fpe_back.sv @@
// Back end: per plane, sum of squares, serial square root, four bit-serial
// dividers and saturation, into a one-entry result register. Depends on fpe_pkg.
`timescale 1ns / 1ps
module fpe_back (
  input  logic                clk,
  input  logic                rst_n,
  output logic                q_pop,
  input  logic                q_empty,
  input  fpe_pkg::raw_plane_t q_data,
  output logic                out_empty,
  input  logic                out_pop,
  output fpe_pkg::out_item_t  out_data
);

  localparam int CW = fpe_pkg::CNT_W;
  localparam int NW = fpe_pkg::NUM_W;

  fpe_pkg::back_state_t state_r, state_nxt;
  fpe_pkg::raw_plane_t  plane_r;
  logic [CW-1:0]        cnt_r;
  logic [65:0]          prod_r;
  logic [67:0]          sum_r;
  logic [34:0]          rem_r;
  logic [33:0]          root_r;
  logic [NW-1:0]        dnum_r [4];
  logic [34:0]          drem_r [4];
  fpe_pkg::out_item_t   res_r;
  logic                 res_valid_r;

  logic                 load_res;
  logic [32:0]          mul_in;
  logic [36:0]          rem2;
  logic [35:0]          trial;
  fpe_pkg::out_item_t   res_nxt;

  assign out_empty = !res_valid_r;
  assign out_data  = res_r;
  assign mul_in    = fpe_pkg::mag(plane_r.e[cnt_r[1:0]]);
  assign rem2      = {rem_r, sum_r[67:66]};
  assign trial     = {root_r, 2'b01};

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    load_res  = 1'b0;
    case (state_r)
      fpe_pkg::B_IDLE: if (!q_empty) begin
        q_pop     = 1'b1;
        state_nxt = fpe_pkg::B_SQ;
      end
      fpe_pkg::B_SQ:   if (cnt_r == CW'(3)) state_nxt = fpe_pkg::B_SQRT;
      fpe_pkg::B_SQRT: begin
        if (cnt_r == CW'(fpe_pkg::SQRT_STEPS - 1)) begin
          // zero length only when all three elements are zero
          if (rem2 >= {1'b0, trial} || root_r != 34'd0) state_nxt = fpe_pkg::B_DIV;
          else                                           state_nxt = fpe_pkg::B_OUT;
        end
      end
      fpe_pkg::B_DIV:  if (cnt_r == CW'(NW - 1)) state_nxt = fpe_pkg::B_OUT;
      fpe_pkg::B_OUT:  if (!res_valid_r || out_pop) begin
        load_res  = 1'b1;
        state_nxt = fpe_pkg::B_IDLE;
      end
      default:         state_nxt = fpe_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    res_nxt.plane_index = plane_r.idx;
    res_nxt.last_plane  = (plane_r.idx == fpe_pkg::PLANE_FAR);
    res_nxt.degenerate  = (root_r == 34'd0);
    if (root_r == 34'd0) begin
      res_nxt.plane_a = '0;
      res_nxt.plane_b = '0;
      res_nxt.plane_c = '0;
      res_nxt.plane_d = '0;
    end else begin
      res_nxt.plane_a = fpe_pkg::sat_q(dnum_r[0], plane_r.e[0][32]);
      res_nxt.plane_b = fpe_pkg::sat_q(dnum_r[1], plane_r.e[1][32]);
      res_nxt.plane_c = fpe_pkg::sat_q(dnum_r[2], plane_r.e[2][32]);
      res_nxt.plane_d = fpe_pkg::sat_q(dnum_r[3], plane_r.e[3][32]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpe_pkg::B_IDLE;
      res_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_res)     res_valid_r <= 1'b1;
      else if (out_pop) res_valid_r <= 1'b0;
      if (state_nxt != state_r) cnt_r <= '0;
      else                      cnt_r <= cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    logic [35:0] r2;
    if (q_pop) begin
      plane_r <= q_data;
      sum_r   <= '0;
    end
    if (load_res) res_r <= res_nxt;
    case (state_r)
      fpe_pkg::B_SQ: begin
        prod_r <= 66'(mul_in) * 66'(mul_in);
        if (cnt_r != '0) sum_r <= sum_r + 68'(prod_r);
        rem_r  <= '0;
        root_r <= '0;
      end
      fpe_pkg::B_SQRT: begin
        sum_r <= {sum_r[65:0], 2'b00};
        if (rem2 >= {1'b0, trial}) begin
          rem_r  <= 35'(rem2 - {1'b0, trial});
          root_r <= {root_r[32:0], 1'b1};
        end else begin
          rem_r  <= rem2[34:0];
          root_r <= {root_r[32:0], 1'b0};
        end
        for (int j = 0; j < 4; j++) begin
          dnum_r[j] <= {fpe_pkg::mag(plane_r.e[j]), {fpe_pkg::FRAC_BITS{1'b0}}};
          drem_r[j] <= '0;
        end
      end
      fpe_pkg::B_DIV: begin
        // restoring division, one quotient bit per lane per cycle
        for (int j = 0; j < 4; j++) begin
          r2 = {drem_r[j], dnum_r[j][NW-1]};
          if (r2 >= {2'b00, root_r}) begin
            drem_r[j] <= 35'(r2 - {2'b00, root_r});
            dnum_r[j] <= {dnum_r[j][NW-2:0], 1'b1};
          end else begin
            drem_r[j] <= r2[34:0];
            dnum_r[j] <= {dnum_r[j][NW-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.degenerate |->
      res_r.plane_a == 0 && res_r.plane_b == 0 && res_r.plane_c == 0 && res_r.plane_d == 0)
    else $error("degenerate plane not zeroed");
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> res_r.last_plane == (res_r.plane_index == fpe_pkg::PLANE_FAR))
    else $error("last mark off the far plane");
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && !out_pop |=> res_valid_r && $stable(res_r))
    else $error("waiting result overwritten");

endmodule

@@ rtl/frustum_plane_extraction.sv @@
// Frustum plane extraction: takes a view-projection matrix one column per beat and
// returns its six normalized clip planes, left, right, top, bottom, near, far.
// Each matrix is four input beats; after the fourth the block forms the six raw
// planes, and the back end takes one plane at a time through the sum of
// squares, the two-bit-a-step square root, the four parallel bit-serial dividers
// and the handoff. The serial root and dividers set the throughput. A plane with
// a zero normal skips the dividers. After the fourth column in_full stays high
// until the two-entry internal queue has taken the sixth plane, later still while
// results wait. A plane whose normal is zero comes out as zeros with degenerate set.
`timescale 1ns / 1ps
module frustum_plane_extraction (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  fpe_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output fpe_pkg::out_item_t out_data
);

  logic                f_push, q_full, q_pop, q_empty;
  fpe_pkg::raw_plane_t f_data, q_data;

  fpe_front u_front (
    .clk(clk), .rst_n(rst_n), .push(in_push), .full(in_full), .col(in_data),
    .q_push(f_push), .q_full(q_full), .q_data(f_data)
  );

  fpe_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(f_push), .full(q_full), .wdata(f_data),
    .pop(q_pop), .empty(q_empty), .rdata(q_data)
  );

  fpe_back u_back (
    .clk(clk), .rst_n(rst_n), .q_pop(q_pop), .q_empty(q_empty), .q_data(q_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

endmodule

@@ tb/frustum_plane_extraction_tb.sv @@
// Testbench for frustum_plane_extraction: drives matrix columns, predicts the six
// normalized clip planes per matrix and checks every result beat in order.
// Depends on fpe_pkg and the block's RTL.
`timescale 1ns / 1ps
module frustum_plane_extraction_tb;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  fpe_pkg::in_item_t  in_data;
  logic               out_empty;
  logic               out_pop;
  fpe_pkg::out_item_t out_data;

  frustum_plane_extraction dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  fpe_pkg::in_item_t  column_q[$];
  fpe_pkg::out_item_t plane_q[$];
  logic [31:0] matrix_words[16];
  int unsigned col_cnt;
  int unsigned send_idle_pct, recv_idle_pct;
  bit          recv_hold;
  int          hold_cycles;
  int          mismatches;
  longint      cycles;

  task automatic put_column(input fpe_pkg::in_item_t c);
    column_q.insert(column_q.size(), c);
  endtask

  task automatic put_plane(input fpe_pkg::out_item_t r);
    plane_q.insert(plane_q.size(), r);
  endtask

  // floor(sqrt(n)), n below 2^68
  function automatic logic [34:0] isqrt68(input logic [67:0] n);
    logic [34:0] r;
    logic [34:0] c;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (35'd1 << b);
      if ({37'd0, c} * {37'd0, c} <= {4'd0, n}) r = c;
    end
    return r;
  endfunction

  function automatic logic [31:0] norm_div(input logic signed [32:0] e,
                                           input logic [34:0] len);
    logic [32:0] m;
    logic [fpe_pkg::NUM_W-1:0] q;
    m = e[32] ? -e : e;
    q = ({{(fpe_pkg::NUM_W-33){1'b0}}, m} << fpe_pkg::FRAC_BITS) / len;
    if (e[32]) begin
      if (q > 64'h8000_0000) return 32'h8000_0000;
      return -q[31:0];
    end
    if (q > 64'h7fff_ffff) return 32'h7fff_ffff;
    return q[31:0];
  endfunction

  // store one column; on the fourth, queue the six planes
  task automatic predict_planes(input fpe_pkg::in_item_t c);
    logic signed [32:0] e[4];
    logic signed [32:0] w, v;
    logic [67:0] sumsq;
    logic [34:0] len;
    logic [32:0] m;
    fpe_pkg::out_item_t r;
    matrix_words[col_cnt*4+0] = c.col_x;
    matrix_words[col_cnt*4+1] = c.col_y;
    matrix_words[col_cnt*4+2] = c.col_z;
    matrix_words[col_cnt*4+3] = c.col_w;
    if (col_cnt != 3) begin
      col_cnt++;
      return;
    end
    col_cnt = 0;
    for (int p = fpe_pkg::PLANE_LEFT; p <= fpe_pkg::PLANE_FAR; p++) begin
      sumsq = '0;
      for (int j = 0; j < 4; j++) begin
        w = $signed(matrix_words[j*4+3]);
        v = $signed(matrix_words[j*4+p/2]);
        e[j] = (p == fpe_pkg::PLANE_LEFT || p == fpe_pkg::PLANE_BOTTOM ||
                p == fpe_pkg::PLANE_NEAR) ? w + v : w - v;
        if (j < 3) begin
          m = e[j][32] ? -e[j] : e[j];
          sumsq += {35'd0, m} * {35'd0, m};
        end
      end
      len = isqrt68(sumsq);
      r.degenerate = (len == 0);
      r.plane_a = r.degenerate ? '0 : norm_div(e[0], len);
      r.plane_b = r.degenerate ? '0 : norm_div(e[1], len);
      r.plane_c = r.degenerate ? '0 : norm_div(e[2], len);
      r.plane_d = r.degenerate ? '0 : norm_div(e[3], len);
      r.plane_index = p[2:0];
      r.last_plane = (p == fpe_pkg::PLANE_FAR);
      put_plane(r);
    end
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
      3: return $signed($urandom_range(0, 8'hff)) - 128;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_matrix(input int kind);
    fpe_pkg::in_item_t c;
    for (int k = 0; k < 4; k++) begin
      c = {rand_word(), rand_word(), rand_word(), rand_word()};
      // near-projection-like: small xyz, with some zeros to hit degenerate normals
      if (kind == 1) begin
        c.col_x = $urandom_range(0, 3) == 0 ? 32'd0 : c.col_x >>> 12;
        c.col_y = $urandom_range(0, 3) == 0 ? 32'd0 : c.col_y >>> 12;
        c.col_z = $urandom_range(0, 3) == 0 ? 32'd0 : c.col_z >>> 12;
      end
      put_column(c);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        predict_planes(in_data);
        void'(column_q.pop_front());
      end
      if ((in_push && in_full) ||
          (column_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)) begin
        in_push <= 1'b1;
        in_data <= column_q[0];
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (plane_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected plane beat %p", out_data);
        end else begin
          if (out_data !== plane_q[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("plane mismatch: expected %p got %p", plane_q[0], out_data);
          end
          void'(plane_q.pop_front());
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_pop <= 1'b0;
      end else if (recv_hold) begin
        hold_cycles <= 6000;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3_000_000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic drain();
    while (column_q.size() != 0 || in_push || plane_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    fpe_pkg::in_item_t c;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    out_pop = 1'b0;
    col_cnt = 0;
    mismatches = 0;
    cycles = 0;
    recv_hold = 0;
    hold_cycles = 0;
    send_idle_pct = 23;
    recv_idle_pct = 68;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: identity, extremes, all-zero (all degenerate), saturating offset
    for (int k = 0; k < 4; k++) begin
      c = '0;
      if (k == 0) c.col_x = 32'h0001_0000;
      if (k == 1) c.col_y = 32'h0001_0000;
      if (k == 2) c.col_z = 32'h0001_0000;
      if (k == 3) c.col_w = 32'h0001_0000;
      put_column(c);
    end
    repeat (4) put_column('0);
    repeat (4) put_column({4{32'h7fff_ffff}});
    repeat (4) put_column({4{32'h8000_0000}});
    for (int k = 0; k < 4; k++) begin
      c = '0;
      c.col_w = k == 3 ? 32'h7fff_ffff : 32'h8000_0000;
      c.col_x = k == 0 ? 32'd1 : 32'd0;
      put_column(c);
    end
    drain();
    // sender pause until all results are out
    repeat (20) @(posedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 23 : phase == 1 ? 68 : 0;
      recv_idle_pct = phase == 0 ? 68 : phase == 1 ? 23 : 0;
      if (phase == 2) begin
        recv_hold <= 1'b1;
        @(posedge clk);
        recv_hold <= 1'b0;
      end
      for (int m = 0; m < 22; m++) add_matrix($urandom_range(0, 2) == 0);
      drain();
    end

    repeat (700) @(posedge clk);
    if (mismatches == 0 && plane_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ sim.f @@
rtl/fpe_pkg.sv
rtl/fpe_front.sv
rtl/fpe_queue.sv
rtl/fpe_back.sv
rtl/frustum_plane_extraction.sv
tb/frustum_plane_extraction_tb.sv
